// File: rtl/core/mseu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mseu_pkg
// Commands, sequencer states and shared types of the MIPS subset execute unit.
// ----------------------------------------------------------------------------
package mseu_pkg;

    typedef enum logic [3:0] {
        CMD_ADD  = 4'd0,
        CMD_SUB  = 4'd1,
        CMD_MUL  = 4'd2,
        CMD_DIV  = 4'd3,
        CMD_ADDI = 4'd4,
        CMD_SUBI = 4'd5,
        CMD_LW   = 4'd6,
        CMD_SW   = 4'd7,
        CMD_BEQ  = 4'd8,
        CMD_J    = 4'd9
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_ITER,
        ST_FIX,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } iter_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_sts_t;

    localparam int DATA_W  = 32;
    localparam int REG_AW  = 5;
    localparam int OFF_W   = 12;
    localparam int TGT_W   = 10;
    localparam int CNT_W   = 6;

endpackage
`default_nettype wire

// File: rtl/core/mseu_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mseu_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mseu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

// File: rtl/core/mseu_muldiv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mseu_muldiv
// Shared shift/add unit: 32-step shift-add multiply or restoring divide.
// ----------------------------------------------------------------------------
module mseu_muldiv
    import mseu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire iter_ctl_t         ctl,
    input  wire logic [DATA_W-1:0] a,
    input  wire logic [DATA_W-1:0] b,
    output iter_sts_t              sts,
    output logic      [DATA_W-1:0] result
);

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    op_t               op_reg, op_next;
    logic              neg_reg, neg_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic [DATA_W:0]   trial;
    logic [DATA_W-1:0] abs_a, abs_b;

    assign abs_a = a[DATA_W-1] ? (~a + 1'b1) : a;
    assign abs_b = b[DATA_W-1] ? (~b + 1'b1) : b;
    assign trial = {acc_reg, q_reg[DATA_W-1]} - {1'b0, d_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = ctl.op;
            acc_next  = '0;
            if (ctl.op == OP_MUL)
            begin
                q_next = b;
                d_next = a;
            end
            else
            begin
                q_next   = abs_a;
                d_next   = abs_b;
                neg_next = a[DATA_W-1] ^ b[DATA_W-1];
            end
        end
        else if (busy_reg)
        begin
            if (op_reg == OP_MUL)
            begin
                if (q_reg[0])
                begin
                    acc_next = acc_reg + d_reg;
                end
                q_next = q_reg >> 1;
                d_next = d_reg << 1;
            end
            else
            begin
                if (!trial[DATA_W])
                begin
                    acc_next = trial[DATA_W-1:0];
                    q_next   = {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = {acc_reg[DATA_W-2:0], q_reg[DATA_W-1]};
                    q_next   = {q_reg[DATA_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
    end

    always_comb
    begin
        if (op_reg == OP_MUL)
        begin
            result = acc_reg;
        end
        else
        begin
            result = neg_reg ? (~q_reg + 1'b1) : q_reg;
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule
`default_nettype wire

// File: rtl/core/mips_subset_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_subset_execute_unit
// Executes one decoded MIPS-subset instruction per input beat.
// ----------------------------------------------------------------------------
// Input beat on s_axis carries one decoded instruction; output beat on
// m_axis carries its single result (register write, redirect, div flag).
// From input accept, add/sub/addi/subi/beq/j and a div by zero go from
// ST_READ (A, then B) to ST_DONE; lw/sw pass through ST_FIX, and mul and
// div through ST_ITER, where they iterate 32 times through the shared
// shift/add unit. m_axis_tvalid is high in ST_DONE.
// The register file is read one port per cycle (A then B). One beat is
// in flight at a time; s_axis_tready is low while working and while a
// result waits. If the receiver stalls, the result holds in the output
// register and no new beat is taken.
// After reset the block sweeps the data memory to zero, one word per
// cycle; the register file (32 entries) uses valid bits. s_axis_tready
// stays low during the sweep.
// ----------------------------------------------------------------------------
module mips_subset_execute_unit
    import mseu_pkg::*;
#(
    parameter int MEM_WORDS     = 1024,
    parameter int PROGRAM_DEPTH = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[3:0], dest_reg[8:4], src_a_reg[13:9], src_b_reg[18:14],
    // immediate[50:19], mem_offset[62:51], target_index[72:63], zero pad
    input  wire logic [79:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // reg_written[0], written_reg[5:1], written_value[37:6], redirect[38],
    // redirect_target[48:39], divide_by_zero[49], zero pad
    output logic [55:0]      m_axis_tdata
);

    localparam int MAW = $clog2(MEM_WORDS);
    localparam int PAW = $clog2(PROGRAM_DEPTH);

    state_t state_reg, state_next;

    logic [3:0]        cmd_reg;
    logic [REG_AW-1:0] rd_reg, ra_reg, rb_reg;
    logic [DATA_W-1:0] imm_reg, a_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [TGT_W-1:0]  tgt_reg;
    logic              phase_reg;
    logic [MAW-1:0]    clr_reg;
    logic [31:0]       rvalid_reg;
    logic [DATA_W-1:0] rf [32];
    logic [DATA_W-1:0] rf_rd;

    logic              o_wr_reg, o_redir_reg, o_dz_reg;
    logic [REG_AW-1:0] o_rd_reg;
    logic [DATA_W-1:0] o_val_reg;
    logic [TGT_W-1:0]  o_tgt_reg;

    iter_ctl_t         md_ctl;
    iter_sts_t         md_sts;
    logic [DATA_W-1:0] md_res;

    logic              mem_we;
    logic [MAW-1:0]    mem_addr, mem_idx;
    logic [DATA_W-1:0] mem_wdata, mem_rdata;
    logic              rd_phase;

    logic              r_wr, r_redir, r_dz;
    logic [DATA_W-1:0] r_val;
    logic [PAW-1:0]    tgt_mod;
    logic [TGT_W-1:0]  tgt_inc;

    logic              in_fire;
    assign in_fire = s_axis_tvalid && s_axis_tready;

    assign mem_idx = MAW'(MEM_WORDS - 1) - MAW'(off_reg[OFF_W-1:2]);

    // operand B goes in straight from the register file read at start
    mseu_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (md_ctl),
        .a      (a_reg),
        .b      (rf_rd),
        .sts    (md_sts),
        .result (md_res)
    );

    mseu_ram #(.WIDTH(DATA_W), .DEPTH(MEM_WORDS)) u_dmem (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == MAW'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (phase_reg)
                begin
                    if (cmd_reg == CMD_MUL || (cmd_reg == CMD_DIV && rd_phase))
                    begin
                        state_next = ST_ITER;
                    end
                    else if (cmd_reg == CMD_LW || cmd_reg == CMD_SW)
                    begin
                        state_next = ST_FIX;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_ITER:
            begin
                if (md_sts.done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FIX:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // rd_phase: divisor nonzero
    assign rd_phase = (rf_rd != '0);

    // outputs
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = (state_reg == ST_DONE);
        md_ctl.start  = (state_reg == ST_READ) && phase_reg &&
                        (cmd_reg == CMD_MUL || (cmd_reg == CMD_DIV && rd_phase));
        md_ctl.op     = (cmd_reg == CMD_DIV) ? OP_DIV : OP_MUL;
        mem_we        = 1'b0;
        mem_addr      = mem_idx;
        mem_wdata     = a_reg;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_addr  = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == ST_FIX && cmd_reg == CMD_SW)
        begin
            mem_we = 1'b1;
        end
    end

    assign rf_rd = (phase_reg ? (rvalid_reg[rb_reg] && rb_reg != '0 ? rf[rb_reg] : '0)
                              : (rvalid_reg[ra_reg] && ra_reg != '0 ? rf[ra_reg] : '0));

    // result formation
    assign tgt_mod = PAW'(tgt_reg);
    assign tgt_inc = TGT_W'((tgt_mod == PAW'(PROGRAM_DEPTH - 1)) ? '0 : tgt_mod + 1'b1);

    always_comb
    begin
        r_wr    = 1'b0;
        r_redir = 1'b0;
        r_dz    = 1'b0;
        r_val   = '0;
        case (cmd_reg)
            CMD_ADD:  begin r_wr = 1'b1; r_val = a_reg + rf_rd;   end
            CMD_SUB:  begin r_wr = 1'b1; r_val = a_reg - rf_rd;   end
            CMD_ADDI: begin r_wr = 1'b1; r_val = a_reg + imm_reg; end
            CMD_SUBI: begin r_wr = 1'b1; r_val = a_reg - imm_reg; end
            CMD_MUL:
            begin
                r_wr  = 1'b1;
                r_val = md_res;
            end
            CMD_DIV:
            begin
                // finishing straight from the read means a zero divisor
                if (state_reg == ST_READ)
                begin
                    r_dz = 1'b1;
                end
                else
                begin
                    r_wr  = 1'b1;
                    r_val = md_res;
                end
            end
            CMD_LW:   begin r_wr = 1'b1; r_val = mem_rdata; end
            CMD_BEQ:  r_redir = (a_reg == rf_rd);
            CMD_J:    r_redir = 1'b1;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            phase_reg  <= 1'b0;
            rvalid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (in_fire)
            begin
                phase_reg <= 1'b0;
            end
            else if (state_reg == ST_READ)
            begin
                phase_reg <= 1'b1;
            end
            if (state_reg == ST_DONE && m_axis_tready && o_wr_reg)
            begin
                rvalid_reg[o_rd_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg <= s_axis_tdata[3:0];
            rd_reg  <= s_axis_tdata[8:4];
            ra_reg  <= s_axis_tdata[13:9];
            rb_reg  <= s_axis_tdata[18:14];
            imm_reg <= s_axis_tdata[50:19];
            off_reg <= s_axis_tdata[62:51];
            tgt_reg <= s_axis_tdata[72:63];
        end
        if (state_reg == ST_READ && !phase_reg)
        begin
            a_reg <= rf_rd;
        end
        if (state_reg == ST_DONE && m_axis_tready && o_wr_reg)
        begin
            rf[o_rd_reg] <= o_val_reg;
        end
        if ((state_reg == ST_READ && phase_reg && !md_ctl.start &&
             cmd_reg != CMD_LW && cmd_reg != CMD_SW) ||
            (state_reg == ST_ITER && md_sts.done) || state_reg == ST_FIX)
        begin
            o_wr_reg    <= r_wr && rd_reg != '0;
            o_rd_reg    <= (r_wr && rd_reg != '0) ? rd_reg : '0;
            o_val_reg   <= (r_wr && rd_reg != '0) ? r_val : '0;
            o_redir_reg <= r_redir;
            o_tgt_reg   <= r_redir ? tgt_inc : '0;
            o_dz_reg    <= r_dz;
        end
    end

    assign m_axis_tdata = {6'd0, o_dz_reg, o_tgt_reg, o_redir_reg, o_val_reg, o_rd_reg, o_wr_reg};

endmodule
`default_nettype wire

// File: rtl/core/mseu_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mseu_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module mseu_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while result pending");

    a_no_accept_after: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("back-to-back accept");

    a_dz_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[49]) |-> !m_axis_tdata[0])
        else $error("write on zero divisor");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind mips_subset_execute_unit mseu_checker u_mseu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
